@@ src/tpe_pkg.sv @@
package tpe_pkg;

    localparam int SAMPLE_W             = 16;
    localparam int CFG_W                = 16;
    localparam int ALPHA_W              = 17;
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 17;
    localparam int ANGLE_W              = 16;

    localparam int DEF_CORDIC_ITERS     = 16;
    localparam int DEF_SMOOTH_FRAC_BITS = 16;

    localparam int ANG_TAB_LEN          = 24;
    localparam int ITER_W               = $clog2(ANG_TAB_LEN);

    localparam int DOT_W                = 34;
    localparam int CORDIC_FRAC          = 16;
    localparam int CORDIC_W             = DOT_W + CORDIC_FRAC + 2;
    localparam int Z_W                  = 32;
    localparam int MAG_W                = 31;
    localparam int CDEG_CONST_W         = 29;
    localparam int SCALE_W              = MAG_W + CDEG_CONST_W;
    localparam int CDEG_SHIFT           = 45;

    localparam int ALPHA_FRAC           = 16;

    localparam logic signed [Z_W-1:0]      HALF_PI_Q29      = 32'sd843314857;
    localparam logic [CDEG_CONST_W-1:0]    CDEG_PER_RAD_Q16 = 29'd375493621;
    localparam logic signed [ANGLE_W-1:0]  CDEG_LIMIT       = 16'sd18000;
    localparam logic [ALPHA_W-1:0]         ALPHA_ONE        = 17'd65536;

    localparam logic signed [CFG_W-1:0] RST_GRAV_X = 16'sd0;
    localparam logic signed [CFG_W-1:0] RST_GRAV_Y = 16'sd0;
    localparam logic signed [CFG_W-1:0] RST_GRAV_Z = 16'sd16384;
    localparam logic signed [CFG_W-1:0] RST_FWD_X  = 16'sd16384;
    localparam logic signed [CFG_W-1:0] RST_FWD_Y  = 16'sd0;
    localparam logic signed [CFG_W-1:0] RST_FWD_Z  = 16'sd0;
    localparam logic [ALPHA_W-1:0]      RST_ALPHA  = 17'd6554;

    localparam logic signed [Z_W-1:0] ATAN_Q29 [ANG_TAB_LEN] = '{
        32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
        32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
        32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
        32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
        32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
        32'sd512,       32'sd256,       32'sd128,       32'sd64
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRAV_X = 3'd0,
        CFG_GRAV_Y = 3'd1,
        CFG_GRAV_Z = 3'd2,
        CFG_FWD_X  = 3'd3,
        CFG_FWD_Y  = 3'd4,
        CFG_FWD_Z  = 3'd5,
        CFG_ALPHA  = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch_centideg;
        logic signed [ANGLE_W-1:0] smoothed_centideg;
    } out_item_t;

    typedef struct packed {
        logic              load;
        logic              dot_en;
        axis_t             dot_sel;
        logic              pre;
        logic              rot;
        logic [ITER_W-1:0] iter;
        logic              scale;
        logic              pitch;
        logic              diff;
        logic              mul;
        logic              add;
        logic              out_load;
    } tpe_cmd_t;

endpackage

@@ src/tpe_ctrl.sv @@
module tpe_ctrl #(
    parameter int CORDIC_ITERS = tpe_pkg::DEF_CORDIC_ITERS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_zero,
    output logic             out_valid,
    input  logic             out_ready,
    output tpe_pkg::tpe_cmd_t cmd
);
    import tpe_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DOT   = 10'b0000000010,
        S_PRE   = 10'b0000000100,
        S_ROT   = 10'b0000001000,
        S_SCALE = 10'b0000010000,
        S_PITCH = 10'b0000100000,
        S_DIFF  = 10'b0001000000,
        S_MUL   = 10'b0010000000,
        S_ADD   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_ITERS - 1);

    state_t            state_reg, state_next;
    axis_t             axis_reg, axis_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        iter_next      = iter_reg;
        cmd            = '0;
        cmd.dot_sel    = axis_reg;
        cmd.iter       = iter_reg;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !in_zero)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = AXIS_X;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                cmd.dot_en = 1'b1;
                if (axis_reg == AXIS_Z)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    axis_next = axis_t'(axis_reg + 2'd1);
                end
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                iter_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    iter_next = iter_reg + ITER_W'(1);
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_PITCH;
            end
            S_PITCH:
            begin
                cmd.pitch  = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_X;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/tpe_datapath.sv @@
module tpe_datapath #(
    parameter int SMOOTH_FRAC_BITS = tpe_pkg::DEF_SMOOTH_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tpe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tpe_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  tpe_pkg::in_item_t                   in_item,
    output logic                                in_zero,
    input  tpe_pkg::tpe_cmd_t                   cmd,
    output tpe_pkg::out_item_t                  out_item
);
    import tpe_pkg::*;

    localparam int ACC_W  = ANGLE_W + SMOOTH_FRAC_BITS;
    localparam int DIFF_W = ACC_W + 1;
    localparam int MUL_W  = DIFF_W + ALPHA_W + 1;
    localparam int SM_W   = ACC_W + 1 - SMOOTH_FRAC_BITS;

    localparam logic signed [MUL_W-1:0] STEP_HALF = MUL_W'(1) <<< (ALPHA_FRAC - 1);
    localparam logic signed [ACC_W:0]   SM_HALF   = (ACC_W + 1)'(1) <<< (SMOOTH_FRAC_BITS - 1);
    localparam logic [SCALE_W:0]        SCALE_HALF = (SCALE_W + 1)'(1) << (CDEG_SHIFT - 1);

    // configuration
    logic signed [CFG_W-1:0] grav_x_reg, grav_y_reg, grav_z_reg;
    logic signed [CFG_W-1:0] fwd_x_reg, fwd_y_reg, fwd_z_reg;
    logic [ALPHA_W-1:0]      alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_x_reg <= RST_GRAV_X;
            grav_y_reg <= RST_GRAV_Y;
            grav_z_reg <= RST_GRAV_Z;
            fwd_x_reg  <= RST_FWD_X;
            fwd_y_reg  <= RST_FWD_Y;
            fwd_z_reg  <= RST_FWD_Z;
            alpha_reg  <= RST_ALPHA;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRAV_X: grav_x_reg <= cfg_data[CFG_W-1:0];
                CFG_GRAV_Y: grav_y_reg <= cfg_data[CFG_W-1:0];
                CFG_GRAV_Z: grav_z_reg <= cfg_data[CFG_W-1:0];
                CFG_FWD_X:  fwd_x_reg  <= cfg_data[CFG_W-1:0];
                CFG_FWD_Y:  fwd_y_reg  <= cfg_data[CFG_W-1:0];
                CFG_FWD_Z:  fwd_z_reg  <= cfg_data[CFG_W-1:0];
                CFG_ALPHA:  alpha_reg  <= cfg_data[ALPHA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_zero = (in_item.accel_x == '0) && (in_item.accel_y == '0)
                     && (in_item.accel_z == '0);

    // dot products, one axis per cycle
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [DOT_W-1:0]    dg_reg, df_reg;
    logic signed [SAMPLE_W-1:0] a_sel;
    logic signed [CFG_W-1:0]    g_sel, f_sel;
    logic signed [2*CFG_W-1:0]  prod_g, prod_f;

    always_comb
    begin
        unique case (cmd.dot_sel)
            AXIS_X:
            begin
                a_sel = ax_reg;
                g_sel = grav_x_reg;
                f_sel = fwd_x_reg;
            end
            AXIS_Y:
            begin
                a_sel = ay_reg;
                g_sel = grav_y_reg;
                f_sel = fwd_y_reg;
            end
            default:
            begin
                a_sel = az_reg;
                g_sel = grav_z_reg;
                f_sel = fwd_z_reg;
            end
        endcase
    end

    assign prod_g = (2*CFG_W)'(a_sel) * (2*CFG_W)'(g_sel);
    assign prod_f = (2*CFG_W)'(a_sel) * (2*CFG_W)'(f_sel);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= in_item.accel_x;
            ay_reg <= in_item.accel_y;
            az_reg <= in_item.accel_z;
            dg_reg <= '0;
            df_reg <= '0;
        end
        else if (cmd.dot_en)
        begin
            dg_reg <= dg_reg + DOT_W'(prod_g);
            df_reg <= df_reg + DOT_W'(prod_f);
        end
    end

    // vectoring cordic
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic                       y_zero_reg, x_neg_reg;
    logic signed [CORDIC_W-1:0] x_init, y_init, dx, dy;

    assign x_init = CORDIC_W'($signed({dg_reg, {CORDIC_FRAC{1'b0}}}));
    assign y_init = CORDIC_W'($signed({df_reg, {CORDIC_FRAC{1'b0}}}));
    assign dx     = y_reg >>> cmd.iter;
    assign dy     = x_reg >>> cmd.iter;

    always_ff @(posedge clk)
    begin
        if (cmd.pre)
        begin
            y_zero_reg <= (df_reg == '0);
            x_neg_reg  <= dg_reg[DOT_W-1];
            if (!x_init[CORDIC_W-1])
            begin
                x_reg <= x_init;
                y_reg <= y_init;
                z_reg <= '0;
            end
            else if (!y_init[CORDIC_W-1])
            begin
                x_reg <= y_init;
                y_reg <= -x_init;
                z_reg <= HALF_PI_Q29;
            end
            else
            begin
                x_reg <= -y_init;
                y_reg <= x_init;
                z_reg <= -HALF_PI_Q29;
            end
        end
        else if (cmd.rot)
        begin
            if (!y_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ATAN_Q29[cmd.iter];
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ATAN_Q29[cmd.iter];
            end
        end
    end

    // radians to centidegrees
    logic signed [Z_W-1:0]  z_abs;
    logic [SCALE_W-1:0]     scale_reg;
    logic [SCALE_W:0]       scale_rnd;
    logic [ANGLE_W-1:0]     cdeg_mag, cdeg_clamped;
    logic signed [ANGLE_W-1:0] last_pitch_reg;

    assign z_abs        = z_reg[Z_W-1] ? -z_reg : z_reg;
    assign scale_rnd    = {1'b0, scale_reg} + SCALE_HALF;
    assign cdeg_mag     = scale_rnd[SCALE_W:CDEG_SHIFT];
    assign cdeg_clamped = (cdeg_mag > CDEG_LIMIT) ? CDEG_LIMIT : cdeg_mag;

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            scale_reg <= SCALE_W'(z_abs[MAG_W-1:0]) * SCALE_W'(CDEG_PER_RAD_Q16);
        end
    end

    // smoothing
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DIFF_W-1:0] diff_reg, pitch_ext;
    logic signed [MUL_W-1:0]  mul_reg, step;
    logic [ALPHA_W-1:0]       alpha_eff;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [ACC_W:0]    sm_sum;
    logic signed [SM_W-1:0]   sm_full;
    logic signed [ANGLE_W-1:0] sm_clamped;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign alpha_s   = $signed({1'b0, alpha_eff});
    assign pitch_ext = DIFF_W'(last_pitch_reg) <<< SMOOTH_FRAC_BITS;
    assign step      = (mul_reg + STEP_HALF) >>> ALPHA_FRAC;

    assign sm_sum  = (ACC_W + 1)'(acc_reg) + SM_HALF;
    assign sm_full = SM_W'(sm_sum >>> SMOOTH_FRAC_BITS);

    always_comb
    begin
        if (sm_full > SM_W'(CDEG_LIMIT))
        begin
            sm_clamped = CDEG_LIMIT;
        end
        else if (sm_full < -SM_W'(CDEG_LIMIT))
        begin
            sm_clamped = -CDEG_LIMIT;
        end
        else
        begin
            sm_clamped = sm_full[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            diff_reg <= pitch_ext - DIFF_W'(acc_reg);
        end
        if (cmd.mul)
        begin
            mul_reg <= MUL_W'(alpha_s) * MUL_W'(diff_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pitch_reg <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (cmd.pitch)
            begin
                if (y_zero_reg)
                begin
                    last_pitch_reg <= x_neg_reg ? CDEG_LIMIT : '0;
                end
                else if (z_reg[Z_W-1])
                begin
                    last_pitch_reg <= -$signed(cdeg_clamped);
                end
                else
                begin
                    last_pitch_reg <= $signed(cdeg_clamped);
                end
            end
            if (cmd.add)
            begin
                acc_reg <= acc_reg + $signed(step[ACC_W-1:0]);
            end
        end
    end

    // result register
    out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.pitch_centideg    <= last_pitch_reg;
            out_reg.smoothed_centideg <= sm_clamped;
        end
    end

    assign out_item = out_reg;

endmodule

@@ src/tilt_pitch_estimator_unit.sv @@
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_item   (accel_x, accel_y, accel_z)
// out       output     out_valid / out_ready  out_item  (pitch_centideg, smoothed_centideg)
// cfg       input      cfg_wr_en              cfg_index, cfg_data
//
// one sample at a time: a transfer, the dot products over the three axes, a pre-rotation,
// CORDIC_ITERS cordic steps, then scaling and smoothing and the output load; the next
// transfer is taken only once the unit is back in idle after that load
// an all-zero sample is dropped in the transfer cycle and ready stays high
// reset clears control and the smoothing state and loads the default calibration
// a held result sits in the output register; the next sample waits at its end for it
module tilt_pitch_estimator_unit #(
    parameter int CORDIC_ITERS     = tpe_pkg::DEF_CORDIC_ITERS,
    parameter int SMOOTH_FRAC_BITS = tpe_pkg::DEF_SMOOTH_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tpe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tpe_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tpe_pkg::out_item_t              out_item
);
    import tpe_pkg::*;

    tpe_cmd_t cmd;
    logic     in_zero;

    tpe_ctrl #(
        .CORDIC_ITERS(CORDIC_ITERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_zero  (in_zero),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    tpe_datapath #(
        .SMOOTH_FRAC_BITS(SMOOTH_FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_item  (in_item),
        .in_zero  (in_zero),
        .cmd      (cmd),
        .out_item (out_item)
    );

endmodule
